>>> sv/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, opcodes and control encodings of the accumulator CPU step.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int ADDR_BITS_DEF = 16;

  // host command codes
  localparam logic [2:0] CMD_WRITE      = 3'd0;
  localparam logic [2:0] CMD_READ       = 3'd1;
  localparam logic [2:0] CMD_SET_PC     = 3'd2;
  localparam logic [2:0] CMD_RESET_REGS = 3'd3;
  localparam logic [2:0] CMD_EXEC       = 3'd4;

  // opcodes
  localparam logic [7:0] OP_NOP      = 8'h01;
  localparam logic [7:0] OP_LDAA_IMM = 8'h86;
  localparam logic [7:0] OP_LDAA_EXT = 8'hB6;
  localparam logic [7:0] OP_STAA_DIR = 8'h97;
  localparam logic [7:0] OP_STAA_EXT = 8'hB7;
  localparam logic [7:0] OP_JMP_EXT  = 8'h7E;
  localparam logic [7:0] OP_INCA     = 8'h4C;
  localparam logic [7:0] OP_SWI      = 8'h3F;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_SWI     = 2'd2;

  // condition code bits
  localparam logic [7:0] CC_FIXED = 8'hC0;
  localparam logic [7:0] CC_I     = 8'h10;
  localparam logic [7:0] CC_N     = 8'h08;
  localparam logic [7:0] CC_Z     = 8'h04;
  localparam logic [7:0] CC_V     = 8'h02;
  localparam logic [7:0] CCR_RESET = CC_FIXED | CC_I | CC_Z;

  localparam logic [7:0] ACC_OVF_FROM = 8'h7F;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] program_counter;
    logic [7:0]  accumulator;
    logic [7:0]  condition_codes;
    logic [7:0]  opcode_seen;
    logic [7:0]  read_data;
    logic [1:0]  status;
  } out_item_t;

  // memory address source
  typedef enum logic [2:0] {
    ASEL_PC,
    ASEL_ITEM,
    ASEL_DIR,
    ASEL_EXT,
    ASEL_CLR
  } asel_t;

  // memory write data source
  typedef enum logic [1:0] {
    WSEL_ZERO,
    WSEL_ITEM,
    WSEL_ACC
  } wsel_t;

  // controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       mem_we;
    asel_t      asel;
    wsel_t      wsel;
    logic       pc_inc;
    logic       pc_load_item;
    logic       pc_load_ext;
    logic       regs_reset;
    logic       op_load;
    logic       hi_load;
    logic       acc_load_mem;
    logic       acc_inc;
    logic       flag_upd;
    logic       rd_load;
    logic       st_load;
    logic [1:0] st_code;
    logic       clr_step;
    logic       out_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] mem_byte;
    logic [7:0] opcode;
    logic       clr_last;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> sv/acs_ram.sv
// ----------------------------------------------------------------------------
// acs_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/acs_dp.sv
// ----------------------------------------------------------------------------
// acs_dp
// Datapath: memory, CPU registers, operand latches and result register.
// ----------------------------------------------------------------------------
module acs_dp #(
  parameter int ADDR_BITS = acs_pkg::ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  acs_pkg::ctrl_t      ctrl,
  output acs_pkg::dp_stat_t   stat,
  input  acs_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output acs_pkg::out_item_t  out_item
);
  import acs_pkg::*;

  localparam int MemDepth = 1 << ADDR_BITS;

  in_item_t             item_r;
  logic [15:0]          pc_r, pc_nxt;
  logic [7:0]           acc_r, acc_nxt;
  logic [7:0]           ccr_r, ccr_nxt;
  logic [7:0]           op_r, hi_r, rd_r;
  logic [1:0]           st_r;
  logic [ADDR_BITS-1:0] clr_cnt_r;
  out_item_t            out_r;
  logic                 out_valid_r;

  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_wdata, mem_rdata;
  logic [15:0]          ext_addr;

  assign ext_addr = {hi_r, mem_rdata};

  always_comb begin
    unique case (ctrl.asel)
      ASEL_PC:   mem_addr = pc_r[ADDR_BITS-1:0];
      ASEL_ITEM: mem_addr = item_r.address[ADDR_BITS-1:0];
      ASEL_DIR:  mem_addr = ADDR_BITS'(mem_rdata);
      ASEL_EXT:  mem_addr = ext_addr[ADDR_BITS-1:0];
      ASEL_CLR:  mem_addr = clr_cnt_r;
      default:   mem_addr = pc_r[ADDR_BITS-1:0];
    endcase
  end

  always_comb begin
    unique case (ctrl.wsel)
      WSEL_ZERO: mem_wdata = 8'h00;
      WSEL_ITEM: mem_wdata = item_r.write_data;
      WSEL_ACC:  mem_wdata = acc_r;
      default:   mem_wdata = 8'h00;
    endcase
  end

  acs_ram #(
    .WIDTH (8),
    .DEPTH (MemDepth)
  ) u_mem (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    priority if (ctrl.acc_load_mem) begin
      acc_nxt = mem_rdata;
    end else if (ctrl.acc_inc) begin
      acc_nxt = acc_r + 8'd1;
    end else begin
      acc_nxt = acc_r;
    end
  end

  // N and Z follow the new accumulator; V only on the INCA step past 0x7F
  always_comb begin
    ccr_nxt = ccr_r;
    if (ctrl.flag_upd) begin
      ccr_nxt = (ccr_r & ~(CC_N | CC_Z | CC_V)) | CC_FIXED;
      if (acc_nxt[7]) ccr_nxt = ccr_nxt | CC_N;
      if (acc_nxt == 8'h00) ccr_nxt = ccr_nxt | CC_Z;
      if (ctrl.acc_inc && acc_r == ACC_OVF_FROM) ccr_nxt = ccr_nxt | CC_V;
    end
  end

  always_comb begin
    priority if (ctrl.pc_load_item) begin
      pc_nxt = item_r.address;
    end else if (ctrl.pc_load_ext) begin
      pc_nxt = ext_addr;
    end else if (ctrl.pc_inc) begin
      pc_nxt = pc_r + 16'd1;
    end else begin
      pc_nxt = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.regs_reset) begin
      pc_r  <= 16'h0000;
      acc_r <= 8'h00;
      ccr_r <= CCR_RESET;
    end else begin
      pc_r  <= pc_nxt;
      acc_r <= acc_nxt;
      ccr_r <= ccr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      item_r <= in_item;
      op_r   <= 8'h00;
      rd_r   <= 8'h00;
      st_r   <= ST_OK;
    end else begin
      if (ctrl.op_load) op_r <= mem_rdata;
      if (ctrl.rd_load) rd_r <= mem_rdata;
      if (ctrl.st_load) st_r <= ctrl.st_code;
    end
    if (ctrl.hi_load) hi_r <= mem_rdata;
    if (ctrl.out_load) begin
      out_r.program_counter <= pc_r;
      out_r.accumulator     <= acc_r;
      out_r.condition_codes <= ccr_r;
      out_r.opcode_seen     <= op_r;
      out_r.read_data       <= rd_r;
      out_r.status          <= st_r;
    end
  end

  assign stat.command  = item_r.command;
  assign stat.mem_byte = mem_rdata;
  assign stat.opcode   = op_r;
  assign stat.clr_last = &clr_cnt_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> sv/acs_ctrl.sv
// ----------------------------------------------------------------------------
// acs_ctrl
// Controller: sequences memory clear, host commands and instruction fetch.
// ----------------------------------------------------------------------------
module acs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  acs_pkg::dp_stat_t stat,
  output acs_pkg::ctrl_t    ctrl
);
  import acs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CMD,
    S_READ,
    S_OP,
    S_IMM,
    S_DIR,
    S_HI,
    S_LO,
    S_LDX,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ctrl      = '0;
    ctrl.asel = ASEL_PC;
    ctrl.wsel = WSEL_ZERO;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        ctrl.mem_we   = 1'b1;
        ctrl.asel     = ASEL_CLR;
        ctrl.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load_item = 1'b1;
          state_nxt      = S_CMD;
        end
      end
      S_CMD: begin
        state_nxt = S_DONE;
        unique case (stat.command)
          CMD_WRITE: begin
            ctrl.mem_we = 1'b1;
            ctrl.asel   = ASEL_ITEM;
            ctrl.wsel   = WSEL_ITEM;
          end
          CMD_READ: begin
            ctrl.asel = ASEL_ITEM;
            state_nxt = S_READ;
          end
          CMD_SET_PC:     ctrl.pc_load_item = 1'b1;
          CMD_RESET_REGS: ctrl.regs_reset = 1'b1;
          CMD_EXEC: begin
            ctrl.pc_inc = 1'b1;
            state_nxt   = S_OP;
          end
          default: ;
        endcase
      end
      S_READ: begin
        ctrl.rd_load = 1'b1;
        state_nxt    = S_DONE;
      end
      S_OP: begin
        ctrl.op_load = 1'b1;
        state_nxt    = S_DONE;
        unique case (stat.mem_byte)
          OP_NOP: ;
          OP_INCA: begin
            ctrl.acc_inc  = 1'b1;
            ctrl.flag_upd = 1'b1;
          end
          OP_SWI: begin
            ctrl.st_load = 1'b1;
            ctrl.st_code = ST_SWI;
          end
          OP_LDAA_IMM: begin
            ctrl.pc_inc = 1'b1;
            state_nxt   = S_IMM;
          end
          OP_STAA_DIR: begin
            ctrl.pc_inc = 1'b1;
            state_nxt   = S_DIR;
          end
          OP_LDAA_EXT, OP_STAA_EXT, OP_JMP_EXT: begin
            ctrl.pc_inc = 1'b1;
            state_nxt   = S_HI;
          end
          default: begin
            ctrl.st_load = 1'b1;
            ctrl.st_code = ST_UNKNOWN;
          end
        endcase
      end
      S_IMM: begin
        ctrl.acc_load_mem = 1'b1;
        ctrl.flag_upd     = 1'b1;
        state_nxt         = S_DONE;
      end
      S_DIR: begin
        ctrl.mem_we   = 1'b1;
        ctrl.asel     = ASEL_DIR;
        ctrl.wsel     = WSEL_ACC;
        ctrl.flag_upd = 1'b1;
        state_nxt     = S_DONE;
      end
      S_HI: begin
        ctrl.hi_load = 1'b1;
        ctrl.pc_inc  = 1'b1;
        state_nxt    = S_LO;
      end
      S_LO: begin
        state_nxt = S_DONE;
        priority if (stat.opcode == OP_LDAA_EXT) begin
          ctrl.asel = ASEL_EXT;
          state_nxt = S_LDX;
        end else if (stat.opcode == OP_STAA_EXT) begin
          ctrl.mem_we   = 1'b1;
          ctrl.asel     = ASEL_EXT;
          ctrl.wsel     = WSEL_ACC;
          ctrl.flag_upd = 1'b1;
        end else begin
          ctrl.pc_load_ext = 1'b1;
        end
      end
      S_LDX: begin
        ctrl.acc_load_mem = 1'b1;
        ctrl.flag_upd     = 1'b1;
        state_nxt         = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> sv/accumulator_cpu_subset_step.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_subset_step
// 8-bit accumulator CPU subset driven by host commands, one result per item.
// ----------------------------------------------------------------------------
// An item passes S_CMD, then S_DONE; a read adds S_READ, an execute S_OP,
// then S_IMM (LDAA imm), S_DIR (STAA dir) or S_HI and S_LO (ext modes), with
// S_LDX for LDAA ext. S_DONE holds until the result register is free.
// The single memory port serves one fetch or access per cycle; an item is
// accepted only in S_IDLE, once the last result is loaded. After reset all
// 2^ADDR_BITS bytes are cleared, one a cycle, before any item is accepted.
module accumulator_cpu_subset_step #(
  parameter int ADDR_BITS = acs_pkg::ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  acs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output acs_pkg::out_item_t out_item
);
  import acs_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t stat;

  acs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  acs_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> sv/acs_checker.sv
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks of the accumulator CPU step, bound to the top level.
// ----------------------------------------------------------------------------
module acs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input acs_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input acs_pkg::out_item_t out_item
);
  import acs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  a_ccr_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.condition_codes[7:6] == 2'b11 && out_item.status <= ST_SWI)
    else $error("bad condition codes or status");

  a_swi_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_SWI |-> out_item.opcode_seen == OP_SWI)
    else $error("SWI status without SWI opcode");

  a_unknown_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_UNKNOWN |->
      out_item.opcode_seen != OP_NOP && out_item.opcode_seen != OP_INCA &&
      out_item.opcode_seen != OP_SWI && out_item.opcode_seen != OP_JMP_EXT &&
      out_item.opcode_seen != OP_LDAA_IMM && out_item.opcode_seen != OP_LDAA_EXT &&
      out_item.opcode_seen != OP_STAA_DIR && out_item.opcode_seen != OP_STAA_EXT)
    else $error("known opcode flagged unknown");

endmodule

bind accumulator_cpu_subset_step acs_checker u_acs_checker (.*);
